### design/bsed_pkg.sv
// Shared types, codes and helpers for the backslash escape decoder.
// No dependencies; front, queue, back and top use it by scoped names.
package bsed_pkg;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_BSLASH = 2'd1;
  localparam logic [1:0] MODE_HEX0   = 2'd2;
  localparam logic [1:0] MODE_HEX1   = 2'd3;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LF     = 8'd10;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Up to three results produced by one input byte.
  typedef struct packed {
    logic [1:0]      count;
    logic            stop;
    logic [2:0][7:0] bytes;
  } res_bundle_t;

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic is_digit;
    logic is_alpha;
    logic [3:0] nib;
    is_digit = (b >= 8'h30) && (b <= 8'h39);
    is_alpha = ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
    nib = is_digit ? b[3:0] : (b[3:0] + 4'd9);
    return {is_digit || is_alpha, nib};
  endfunction

endpackage

### design/bsed_front.sv
// Front end: accepts input bytes, tracks escape state, and builds result bundles.
// Depends on bsed_pkg.
module bsed_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  escape_enable,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  end_of_string,
  input  logic                  q_ready,
  output logic                  q_push,
  output bsed_pkg::res_bundle_t q_data
);

  logic [1:0] decode_mode;
  logic [1:0] decode_mode_next;
  logic [3:0] held_nibble;
  logic [3:0] held_nibble_next;
  logic       halted;
  logic       halted_next;
  logic       accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (q_data.count != 2'd0);

  always_comb begin
    logic [4:0] hx;
    logic       do_plain;
    logic [1:0] n;
    hx               = bsed_pkg::hex_value(in_byte);
    do_plain         = 1'b0;
    n                = 2'd0;
    q_data.bytes     = '0;
    q_data.stop      = 1'b0;
    decode_mode_next = bsed_pkg::MODE_NORMAL;
    held_nibble_next = held_nibble;
    halted_next      = halted;
    if (halted) begin
      decode_mode_next = decode_mode;
    end else if (!escape_enable) begin
      q_data.bytes[0] = in_byte;
      n = 2'd1;
    end else begin
      case (decode_mode)
        bsed_pkg::MODE_NORMAL: begin
          do_plain = 1'b1;
        end
        bsed_pkg::MODE_BSLASH: begin
          n = 2'd1;
          case (in_byte)
            bsed_pkg::CH_C: begin
              q_data.stop = 1'b1;
              halted_next = 1'b1;
            end
            bsed_pkg::CH_BSLASH: q_data.bytes[0] = bsed_pkg::CH_BSLASH;
            bsed_pkg::CH_A:      q_data.bytes[0] = 8'h07;
            bsed_pkg::CH_B:      q_data.bytes[0] = 8'h08;
            bsed_pkg::CH_E:      q_data.bytes[0] = bsed_pkg::CH_ESC;
            bsed_pkg::CH_F:      q_data.bytes[0] = 8'h0C;
            bsed_pkg::CH_N:      q_data.bytes[0] = bsed_pkg::CH_LF;
            bsed_pkg::CH_R:      q_data.bytes[0] = 8'h0D;
            bsed_pkg::CH_T:      q_data.bytes[0] = 8'h09;
            bsed_pkg::CH_V:      q_data.bytes[0] = 8'h0B;
            bsed_pkg::CH_X: begin
              if (end_of_string) begin
                q_data.bytes[0] = bsed_pkg::CH_BSLASH;
                q_data.bytes[1] = bsed_pkg::CH_X;
                n = 2'd2;
              end else begin
                decode_mode_next = bsed_pkg::MODE_HEX0;
                n = 2'd0;
              end
            end
            default: begin
              q_data.bytes[0] = bsed_pkg::CH_BSLASH;
              q_data.bytes[1] = in_byte;
              n = 2'd2;
            end
          endcase
        end
        bsed_pkg::MODE_HEX0: begin
          if (hx[4]) begin
            if (end_of_string) begin
              q_data.bytes[0] = {4'd0, hx[3:0]};
              n = 2'd1;
            end else begin
              held_nibble_next = hx[3:0];
              decode_mode_next = bsed_pkg::MODE_HEX1;
            end
          end else begin
            q_data.bytes[0] = bsed_pkg::CH_BSLASH;
            q_data.bytes[1] = bsed_pkg::CH_X;
            n = 2'd2;
            do_plain = 1'b1;
          end
        end
        default: begin
          if (hx[4]) begin
            q_data.bytes[0] = {held_nibble, hx[3:0]};
          end else begin
            q_data.bytes[0] = {4'd0, held_nibble};
            do_plain = 1'b1;
          end
          n = 2'd1;
        end
      endcase
      // plain text tail: a backslash opens an escape unless the string ends here
      if (do_plain) begin
        if ((in_byte == bsed_pkg::CH_BSLASH) && !end_of_string) begin
          decode_mode_next = bsed_pkg::MODE_BSLASH;
        end else begin
          q_data.bytes[n] = in_byte;
          n = n + 2'd1;
        end
      end
    end
    q_data.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= bsed_pkg::MODE_NORMAL;
      held_nibble <= 4'd0;
      halted      <= 1'b0;
    end else if (accept) begin
      decode_mode <= decode_mode_next;
      held_nibble <= held_nibble_next;
      halted      <= halted_next;
    end
  end

endmodule

### design/bsed_queue.sv
// Short bundle FIFO between the front and back ends.
// Depends on bsed_pkg.
module bsed_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bsed_pkg::res_bundle_t push_data,
  output logic                  push_ready,
  input  logic                  pop,
  output logic                  pop_valid,
  output bsed_pkg::res_bundle_t pop_data
);

  bsed_pkg::res_bundle_t        mem [bsed_pkg::QDepth];
  logic [bsed_pkg::QPtrW-1:0]   wr_ptr;
  logic [bsed_pkg::QPtrW-1:0]   rd_ptr;
  logic [bsed_pkg::QCntW-1:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = (count != bsed_pkg::QCntW'(bsed_pkg::QDepth));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + bsed_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + bsed_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + bsed_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - bsed_pkg::QCntW'(1);
      end
    end
  end

endmodule

### design/bsed_back.sv
// Back end: holds one bundle and emits its results one per cycle while out_ready is high.
// Depends on bsed_pkg.
module bsed_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  bsed_pkg::res_bundle_t q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  stop_marker,
  output logic                  last_of_run
);

  bsed_pkg::res_bundle_t cur;
  logic [1:0]            idx;
  logic                  busy;
  logic                  at_last;

  assign at_last     = (idx == (cur.count - 2'd1));
  assign out_valid   = busy;
  assign out_byte    = cur.bytes[idx];
  assign stop_marker = cur.stop;
  assign last_of_run = at_last;
  assign q_pop       = q_valid && (!busy || (out_ready && at_last));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && out_ready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

### design/backslash_escape_decoder.sv
// Top level of the backslash escape decoder: config register, front, queue, back.
// Depends on bsed_pkg, bsed_front, bsed_queue and bsed_back.
//
// Input channel (in_valid/in_ready) takes one text byte per cycle while
// in_ready is high, with an end_of_string flag. Output channel
// (out_valid/out_ready) gives zero to three results per byte: out_byte,
// stop_marker for a \c sequence, and last_of_run on each byte's final result.
// A result-producing byte is written into the bundle queue when accepted
// and is loaded into the back-end holding register once the back end is free,
// and its first result is then shown from that register.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver is ready; a byte with two or three results holds the back end
// until all are taken; the four-entry bundle queue absorbs those bursts.
// A stalled receiver holds the current result steady; input keeps flowing
// until the queue fills, then in_ready drops. Reset clears the escape state,
// the halt flag and the queue, and sets escape_enable to 1. After \c all input
// is taken and dropped until reset. The user writes escape_enable over APB
// at address 0 only while the block is idle; the block does not enforce it.
module backslash_escape_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        stop_marker,
  output logic        last_of_run
);

  logic                  escape_enable;
  logic                  q_push;
  logic                  q_ready;
  logic                  q_pop;
  logic                  q_valid;
  bsed_pkg::res_bundle_t push_data;
  bsed_pkg::res_bundle_t pop_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, escape_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      escape_enable <= pwdata[0];
    end
  end

  bsed_front u_front (
    .clk           (clk),
    .rst           (rst),
    .escape_enable (escape_enable),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_data        (push_data)
  );

  bsed_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (push_data),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (pop_data)
  );

  bsed_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (pop_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .stop_marker (stop_marker),
    .last_of_run (last_of_run)
  );

endmodule

### design/bsed_checker.sv
// Port-level checks for the backslash escape decoder, bound to the top level.
// Depends only on the top-level ports.
module bsed_checker (
  input logic       clk,
  input logic       rst,
  input logic       pready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       stop_marker,
  input logic       last_of_run
);

  // hold a stalled result steady
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(stop_marker) && $stable(last_of_run))
    else $error("stalled result changed");

  a_stop_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_marker |-> (out_byte == 8'd0) && last_of_run)
    else $error("stop marker result malformed");

  a_stop_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && stop_marker |=> !out_valid)
    else $error("output after stop marker");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && pready)
    else $error("output valid right after reset");

endmodule

bind backslash_escape_decoder bsed_checker u_bsed_checker (
  .clk         (clk),
  .rst         (rst),
  .pready      (pready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .stop_marker (stop_marker),
  .last_of_run (last_of_run)
);

### tb/sv/bsed_tb_pkg.sv
// Predictor and result checker for the backslash escape decoder testbench.
// Depends on bsed_pkg for the decode modes and character codes.
package bsed_tb_pkg;
  import bsed_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       stop;
    logic       last;
  } decoded_t;

  class escape_decode_tracker;
    bit         enable;
    logic [1:0] mode;
    logic [3:0] held;
    bit         halted;
    decoded_t   decoded_q[$];
    logic [7:0] run_data[3];
    bit         run_stop[3];
    int         run_n;
    int         mismatches;
    int         results_seen;
    int         requests_seen;

    function new();
      enable = 1'b1;
      mode = MODE_NORMAL;
      held = 4'h0;
      halted = 1'b0;
      mismatches = 0;
      results_seen = 0;
      requests_seen = 0;
    endfunction

    function void set_enable(bit v);
      enable = v;
    endfunction

    function int nibble_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - int'("0");
      if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
      if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
      return -1;
    endfunction

    function void emit(logic [7:0] d, bit s);
      run_data[run_n] = d;
      run_stop[run_n] = s;
      run_n++;
    endfunction

    function void plain(logic [7:0] b, bit eos);
      // a backslash opens an escape unless it ends the string
      if (b == CH_BSLASH && !eos) mode = MODE_BSLASH;
      else emit(b, 1'b0);
    endfunction

    function void escaped(logic [7:0] b, bit eos);
      case (b)
        CH_C: begin
          halted = 1'b1;
          emit(8'h00, 1'b1);
        end
        CH_BSLASH: emit(CH_BSLASH, 1'b0);
        CH_A: emit(8'h07, 1'b0);
        CH_B: emit(8'h08, 1'b0);
        CH_E: emit(CH_ESC, 1'b0);
        CH_F: emit(8'h0C, 1'b0);
        CH_N: emit(CH_LF, 1'b0);
        CH_R: emit(8'h0D, 1'b0);
        CH_T: emit(8'h09, 1'b0);
        CH_V: emit(8'h0B, 1'b0);
        CH_X: begin
          if (eos) begin
            emit(CH_BSLASH, 1'b0);
            emit(CH_X, 1'b0);
          end else begin
            mode = MODE_HEX0;
          end
        end
        default: begin
          emit(CH_BSLASH, 1'b0);
          emit(b, 1'b0);
        end
      endcase
    endfunction

    function void take_request(logic [7:0] b, bit eos);
      int h;
      logic [1:0] prior;
      decoded_t r;
      requests_seen++;
      if (halted) return;
      prior = mode;
      mode = MODE_NORMAL;
      run_n = 0;
      h = nibble_of(b);
      if (!enable) begin
        emit(b, 1'b0);
      end else begin
        case (prior)
          MODE_NORMAL: plain(b, eos);
          MODE_BSLASH: escaped(b, eos);
          MODE_HEX0: begin
            if (h >= 0) begin
              if (eos) begin
                emit(8'(h), 1'b0);
              end else begin
                held = 4'(h);
                mode = MODE_HEX1;
              end
            end else begin
              emit(CH_BSLASH, 1'b0);
              emit(CH_X, 1'b0);
              plain(b, eos);
            end
          end
          default: begin
            if (h >= 0) begin
              emit({held, 4'(h)}, 1'b0);
            end else begin
              emit({4'h0, held}, 1'b0);
              plain(b, eos);
            end
          end
        endcase
      end
      for (int i = 0; i < run_n; i++) begin
        r.data = run_data[i];
        r.stop = run_stop[i];
        r.last = (i == run_n - 1);
        decoded_q.push_back(r);
      end
    endfunction

    function void flag(string what, decoded_t e, logic [7:0] d, logic s, logic l);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected byte %02h stop %0b last %0b, got byte %02h stop %0b last %0b",
                 what, e.data, e.stop, e.last, d, s, l);
      end
    endfunction

    function void check_result(logic [7:0] d, logic s, logic l);
      decoded_t e;
      results_seen++;
      if (decoded_q.size() == 0) begin
        e = '0;
        flag("unexpected result", e, d, s, l);
        return;
      end
      e = decoded_q.pop_front();
      // the data byte carries no meaning next to a stop marker
      if (e.stop !== s || e.last !== l || (!e.stop && e.data !== d)) begin
        flag("result mismatch", e, d, s, l);
      end
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function bit opens_stop(logic [7:0] b);
      return !halted && enable && mode == MODE_BSLASH && b == CH_C;
    endfunction
  endclass

endpackage

### tb/sv/tb_backslash_escape_decoder.sv
// Top-level testbench for backslash_escape_decoder: clock, reset, APB writes,
// bursty byte requests, a stalling receiver and a watchdog.
// Depends on bsed_pkg, bsed_tb_pkg and the decoder RTL.
module tb_backslash_escape_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import bsed_pkg::*;
  import bsed_tb_pkg::*;

  localparam logic [2:0] REG_ESCAPE_ENABLE = 3'd0;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 16;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        end_of_string;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        stop_marker;
  logic        last_of_run;

  escape_decode_tracker tracker;

  int burst_left    = 0;
  bit offering      = 1'b0;
  bit gapless       = 1'b0;
  bit stop_allowed  = 1'b0;
  int sent          = 0;
  int settings      = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int window_left   = 0;
  int stall_style   = 0;
  int quiet         = 0;

  backslash_escape_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .stop_marker   (stop_marker),
    .last_of_run   (last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: windows of steady, light or heavy stalling, plus requested hold-offs.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (window_left == 0) begin
        window_left = $urandom_range(16, 96);
        stall_style = $urandom_range(0, 2);
      end
      window_left--;
      case (stall_style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.check_result(out_byte, stop_marker, last_of_run);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic bit rand_eos();
    return ($urandom_range(0, 9) == 0);
  endfunction

  task automatic send_request(input logic [7:0] b, input logic eos);
    logic [7:0] v;
    v = b;
    // steer random content away from a stop sequence until the halt phase
    if (!stop_allowed && tracker.opens_stop(v)) v = CH_N;
    if (!gapless) begin
      if (burst_left == 0) begin
        if (offering) in_valid <= 1'b0;
        offering = 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_byte <= v;
    end_of_string <= eos;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.take_request(v, eos);
    sent++;
  endtask

  task automatic send_string(input string s, input bit eos_last);
    for (int i = 0; i < s.len(); i++) send_request(s[i], eos_last && (i == s.len() - 1));
  endtask

  task automatic send_token();
    int k;
    int n;
    logic [7:0] b;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      send_request(8'($urandom_range(1, 255)), rand_eos());
    end else if (k < 60) begin
      case ($urandom_range(0, 8))
        0: b = CH_A;
        1: b = CH_B;
        2: b = CH_E;
        3: b = CH_F;
        4: b = CH_N;
        5: b = CH_R;
        6: b = CH_T;
        7: b = CH_V;
        default: b = CH_BSLASH;
      endcase
      send_request(CH_BSLASH, rand_eos());
      send_request(b, rand_eos());
    end else if (k < 80) begin
      send_request(CH_BSLASH, rand_eos());
      send_request(CH_X, rand_eos());
      repeat ($urandom_range(1, 2)) begin
        n = $urandom_range(0, 15);
        if (n < 10) b = 8'("0" + n);
        else if ($urandom_range(0, 1) != 0) b = 8'("a" + n - 10);
        else b = 8'("A" + n - 10);
        send_request(b, rand_eos());
      end
    end else if (k < 88) begin
      send_request(CH_BSLASH, rand_eos());
      send_request(8'($urandom_range(1, 255)), rand_eos());
    end else if (k < 94) begin
      do b = 8'($urandom_range(1, 255)); while (tracker.nibble_of(b) >= 0);
      send_request(CH_BSLASH, rand_eos());
      send_request(CH_X, rand_eos());
      send_request(b, rand_eos());
    end else begin
      send_request(CH_BSLASH, rand_eos());
    end
  endtask

  task automatic run_phase(input int count);
    int stop_at;
    stop_at = sent + count;
    while (sent < stop_at) send_token();
  endtask

  task automatic drain();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
    // bytes that give no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input bit v);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ESCAPE_ENABLE;
    pwdata <= {31'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_enable(v);
    settings++;
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_byte = '0;
    end_of_string = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_enable(1'b1);
    send_request(8'h01, 1'b0);
    send_request(8'hFF, 1'b0);
    send_string("\\e", 1'b0);
    send_string("\\\\", 1'b0);
    send_string("\\x4a", 1'b0);
    send_string("\\xg", 1'b0);
    send_string("\\xF\\n", 1'b0);
    send_string("\\q", 1'b0);
    send_string("\\", 1'b1);
    send_string("\\x", 1'b1);
    send_string("\\x7", 1'b1);

    run_phase(100);
    write_enable(1'b0);
    run_phase(60);
    write_enable(1'b1);
    run_phase(30);
    // hold the output while requests keep coming, so the queue fills
    hold_requests++;
    gapless = 1'b1;
    run_phase(40);
    gapless = 1'b0;
    run_phase(30);
    write_enable(1'b0);
    run_phase(40);
    write_enable(1'b1);
    run_phase(70);

    // close any open sequence, then halt and confirm input is dropped
    stop_allowed = 1'b1;
    send_request("Z", 1'b1);
    send_string("\\c", 1'b0);
    run_phase(12);
    write_enable(1'b0);
    run_phase(8);
    write_enable(1'b1);
    run_phase(5);
    drain();

    $display("Run covered %0d requests and %0d results over %0d escape settings,",
             tracker.requests_seen, tracker.results_seen, settings);
    $display("including a long output hold-off and a stop sequence with dropped input.");
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
design/bsed_pkg.sv
design/bsed_front.sv
design/bsed_queue.sv
design/bsed_back.sv
design/backslash_escape_decoder.sv
design/bsed_checker.sv
tb/sv/bsed_tb_pkg.sv
tb/sv/tb_backslash_escape_decoder.sv
